// ===== hw/rtl/c3n_pkg.sv =====
// Shared types, constants and state encodings of the 3x3 RGBA convolution block.
`default_nettype none
package c3n_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int ROW_W         = 12;
    localparam int COLQ_W        = 14;
    localparam int ACC_W         = 20;
    localparam int KSUM_W        = 12;
    localparam int KROW_W        = 24;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [10:0] IMAGE_WIDTH_RST  = 11'd1024;
    localparam logic [11:0] IMAGE_HEIGHT_RST = 12'd1024;
    localparam logic [23:0] KERNEL_TOP_RST   = 24'd0;
    localparam logic [23:0] KERNEL_MID_RST   = 24'd256;
    localparam logic [23:0] KERNEL_BOT_RST   = 24'd0;

    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH   = 3'd0,
        REG_IMAGE_HEIGHT  = 3'd1,
        REG_KERNEL_TOP    = 3'd2,
        REG_KERNEL_MIDDLE = 3'd3,
        REG_KERNEL_BOTTOM = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [10:0]              image_width;
        logic [11:0]              image_height;
        logic [2:0][KROW_W-1:0]   kernel_rows;
    } t_cfg;

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic [7:0] in_alpha;
    } t_pix_in;

    typedef struct packed {
        logic [11:0] out_row;
        logic [9:0]  out_col;
        logic [7:0]  out_red;
        logic [7:0]  out_green;
        logic [7:0]  out_blue;
        logic [7:0]  out_alpha;
        logic        last_of_run;
    } t_pix_out;

    // One finished window: raw channel sums, kernel sum and the output span.
    typedef struct packed {
        logic [3:0][ACC_W-1:0] acc;
        logic [KSUM_W-1:0]     ksum;
        logic [ROW_W-1:0]      row_lo;
        logic [ROW_W-1:0]      row_hi;
        logic [COLQ_W-1:0]     col_lo;
        logic [COLQ_W-1:0]     col_hi;
    } t_win;

    typedef enum logic [1:0] {
        F_IDLE,
        F_GATHER,
        F_SEND
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_EMIT
    } t_back_state;

endpackage
`default_nettype wire

// ===== hw/rtl/c3n_front.sv =====
// Front end: pixel intake, line store, window gather and multiply-accumulate.
`default_nettype none
module c3n_front import c3n_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cfg    i_cfg,
    input  wire logic    i_push,
    input  wire t_pix_in i_pix,
    output logic         o_full,
    output logic         o_win_push,
    output t_win         o_win,
    input  wire logic    i_win_full
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int AW = $clog2(3 * MAX_WIDTH);
    localparam logic [1:0] TAP_LAST = 2'd2;

    function automatic logic [1:0] slot_inc(input logic [1:0] s);
        return (s == 2'd2) ? 2'd0 : s + 2'd1;
    endfunction

    // Slot of kernel row k for a window whose newest row sits in slot s.
    function automatic logic [1:0] slot_of(input logic [1:0] s, input logic [1:0] k);
        logic [2:0] t;
        t = 3'(s) + 3'(k) + 3'd1;
        if (t >= 3'd3) t = t - 3'd3;
        return t[1:0];
    endfunction

    t_front_state r_state, n_state;

    logic [ROW_W-1:0] r_row;
    logic [CW-1:0]    r_col;
    logic [1:0]       r_slot;

    logic [CW-1:0]    r_cur_c;
    logic [1:0]       r_cur_slot;
    logic [1:0]       r_tk, r_tl;
    logic             r_issue;
    logic             r_rd_vld;
    logic [1:0]       r_rd_k, r_rd_l;
    logic [31:0]      r_rd_data;
    logic [31:0]      r_mem [3*MAX_WIDTH];

    logic signed [ACC_W-1:0]  r_acc [4];
    logic signed [KSUM_W-1:0] r_ksum;
    logic [ROW_W-1:0]         r_row_lo, r_row_hi;
    logic [COLQ_W-1:0]        r_col_lo, r_col_hi;

    logic [WW-1:0]     w_sat;
    logic [ROW_W-1:0]  h_sat;
    logic [CW-1:0]     c0;
    logic [ROW_W-1:0]  r0;
    logic [1:0]        s0;
    logic [WW-1:0]     c1;
    logic [CW-1:0]     nx_col;
    logic [ROW_W-1:0]  nx_row;
    logic [1:0]        nx_slot;
    logic              window;
    logic [ROW_W-1:0]  cr, row_lo, row_hi;
    logic [COLQ_W-1:0] cc, col_lo, col_hi, wq;
    logic              accept;
    logic              rd_en;
    logic              mac_last;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic signed [7:0] kcoef;
    logic signed [16:0] prod [4];

    assign accept   = i_push && !o_full;
    assign mac_last = r_rd_vld && (r_rd_k == TAP_LAST) && (r_rd_l == TAP_LAST);

    // Frame size saturation.
    always_comb begin
        if (32'(i_cfg.image_width) < 32'd4) begin
            w_sat = WW'(4);
        end else if (32'(i_cfg.image_width) > 32'(MAX_WIDTH)) begin
            w_sat = WW'(MAX_WIDTH);
        end else begin
            w_sat = WW'(i_cfg.image_width);
        end
        h_sat = (i_cfg.image_height < 12'd4) ? 12'd4 : i_cfg.image_height;
    end

    // Position of the incoming pixel, its successor and its window span.
    always_comb begin
        c0 = r_col;
        r0 = r_row;
        s0 = r_slot;
        if (32'(r_col) >= 32'(w_sat)) begin
            c0 = '0;
            r0 = r_row + 12'd1;
            s0 = slot_inc(r_slot);
        end
        if (r0 >= h_sat) begin
            r0 = '0;
            s0 = '0;
        end
        c1 = WW'(c0) + WW'(1);
        if (c1 >= w_sat) begin
            nx_col  = '0;
            nx_row  = r0 + 12'd1;
            nx_slot = slot_inc(s0);
            if (nx_row >= h_sat) begin
                nx_row  = '0;
                nx_slot = '0;
            end
        end else begin
            nx_col  = c1[CW-1:0];
            nx_row  = r0;
            nx_slot = s0;
        end
        window = (r0 >= 12'd3) && (32'(c0) >= 32'd3);
        cr     = r0 - 12'd1;
        row_lo = (cr == 12'd2) ? '0 : cr;
        row_hi = (cr == h_sat - 12'd2) ? h_sat - 12'd1 : cr;
        wq     = COLQ_W'(w_sat);
        cc     = COLQ_W'(c0) - COLQ_W'(1);
        col_lo = (cc == COLQ_W'(2)) ? '0 : cc;
        col_hi = (cc == wq - COLQ_W'(2)) ? wq - COLQ_W'(1) : cc;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (accept && window) n_state = F_GATHER;
            end
            F_GATHER: begin
                if (mac_last) n_state = F_SEND;
            end
            F_SEND: begin
                if (!i_win_full) n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_full     = (r_state != F_IDLE);
        o_win_push = (r_state == F_SEND) && !i_win_full;
        rd_en      = (r_state == F_GATHER) && r_issue;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign wr_addr = AW'(32'(s0) * MAX_WIDTH + 32'(c0));
    assign rd_addr = AW'(32'(slot_of(r_cur_slot, r_tk)) * MAX_WIDTH
                       + 32'(r_cur_c - CW'(2) + CW'(r_tl)));

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem[wr_addr] <= {i_pix.in_alpha, i_pix.in_blue, i_pix.in_green, i_pix.in_red};
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row    <= '0;
            r_col    <= '0;
            r_slot   <= '0;
            r_issue  <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= rd_en;
            if (accept) begin
                r_row  <= nx_row;
                r_col  <= nx_col;
                r_slot <= nx_slot;
                if (window) r_issue <= 1'b1;
            end
            if (rd_en && (r_tk == TAP_LAST) && (r_tl == TAP_LAST)) r_issue <= 1'b0;
        end
    end

    // Tap sequencer: issue reads row by row, left to right.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cur_c    <= c0;
            r_cur_slot <= s0;
            r_tk       <= '0;
            r_tl       <= '0;
            r_row_lo   <= row_lo;
            r_row_hi   <= row_hi;
            r_col_lo   <= col_lo;
            r_col_hi   <= col_hi;
        end else if (rd_en) begin
            r_rd_k <= r_tk;
            r_rd_l <= r_tl;
            if (r_tl == TAP_LAST) begin
                r_tl <= '0;
                r_tk <= r_tk + 2'd1;
            end else begin
                r_tl <= r_tl + 2'd1;
            end
        end
    end

    assign kcoef = $signed(i_cfg.kernel_rows[r_rd_k][8*r_rd_l +: 8]);

    always_comb begin
        for (int b = 0; b < 4; b++) begin
            prod[b] = $signed({1'b0, r_rd_data[8*b +: 8]}) * kcoef;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int b = 0; b < 4; b++) r_acc[b] <= '0;
            r_ksum <= '0;
        end else if (r_rd_vld) begin
            for (int b = 0; b < 4; b++) r_acc[b] <= r_acc[b] + ACC_W'(prod[b]);
            r_ksum <= r_ksum + KSUM_W'(kcoef);
        end
    end

    always_comb begin
        for (int b = 0; b < 4; b++) o_win.acc[b] = r_acc[b];
        o_win.ksum   = r_ksum;
        o_win.row_lo = r_row_lo;
        o_win.row_hi = r_row_hi;
        o_win.col_lo = r_col_lo;
        o_win.col_hi = r_col_hi;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/c3n_fifo.sv =====
// Short queue of finished windows between the front and back ends.
`default_nettype none
module c3n_fifo import c3n_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_win i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output t_win      o_data,
    output logic      o_empty
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    t_win          r_slots [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [NW-1:0] r_count;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + PW'(1);
    endfunction

    assign o_full  = (32'(r_count) == QUEUE_DEPTH);
    assign o_empty = (r_count == '0);
    assign o_data  = r_slots[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_slots[r_wr_ptr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push && !o_full) r_wr_ptr <= ptr_inc(r_wr_ptr);
            if (i_pop && !o_empty) r_rd_ptr <= ptr_inc(r_rd_ptr);
            case ({i_push && !o_full, i_pop && !o_empty})
                2'b10:   r_count <= r_count + NW'(1);
                2'b01:   r_count <= r_count - NW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/c3n_back.sv =====
// Back end: normalize by the kernel sum, clamp, and emit the output span.
`default_nettype none
module c3n_back import c3n_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_win_empty,
    input  wire t_win i_win,
    output logic      o_win_pop,
    output logic      o_empty,
    output t_pix_out  o_res,
    input  wire logic i_pop
);

    localparam int DW = ACC_W + 1;

    t_back_state r_state, n_state;

    logic [ACC_W-1:0]  r_rem [4];
    logic [7:0]        r_q   [4];
    logic [3:0]        r_div_en;
    logic [DW-1:0]     r_dsh;
    logic [2:0]        r_step;
    logic [ROW_W-1:0]  r_i, r_row_hi;
    logic [COLQ_W-1:0] r_j, r_col_lo, r_col_hi;
    logic              r_out_vld;
    t_pix_out          r_out;

    logic              emit;
    logic              span_end;
    logic signed [KSUM_W-1:0] ks;
    logic [KSUM_W-1:0] kabs;
    logic signed [ACC_W-1:0] a_s [4];
    logic [ACC_W-1:0]  a_abs [4];

    assign span_end = (r_i == r_row_hi) && (r_j == r_col_hi);
    assign ks       = $signed(i_win.ksum);
    assign kabs     = ks[KSUM_W-1] ? KSUM_W'(-ks) : KSUM_W'(ks);

    always_comb begin
        for (int b = 0; b < 4; b++) begin
            a_s[b]   = $signed(i_win.acc[b]);
            a_abs[b] = a_s[b][ACC_W-1] ? ACC_W'(-a_s[b]) : ACC_W'(a_s[b]);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (!i_win_empty) n_state = B_DIV;
            end
            B_DIV: begin
                if (r_step == 3'd0) n_state = B_EMIT;
            end
            B_EMIT: begin
                if (emit && span_end) n_state = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_win_pop = (r_state == B_IDLE) && !i_win_empty;
        emit      = (r_state == B_EMIT) && (!r_out_vld || i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_win_pop) begin
            // Classify each channel: pass-through, zero, saturate or divide.
            for (int b = 0; b < 4; b++) begin
                r_rem[b]    <= a_abs[b];
                r_q[b]      <= '0;
                r_div_en[b] <= 1'b0;
                if (ks == '0) begin
                    if (a_s[b][ACC_W-1]) begin
                        r_q[b] <= '0;
                    end else if (a_s[b] > ACC_W'(255)) begin
                        r_q[b] <= 8'd255;
                    end else begin
                        r_q[b] <= a_s[b][7:0];
                    end
                end else if (a_s[b][ACC_W-1] != ks[KSUM_W-1]) begin
                    r_q[b] <= '0;
                end else if (DW'(a_abs[b]) >= (DW'(kabs) << 8)) begin
                    r_q[b] <= 8'd255;
                end else begin
                    r_div_en[b] <= 1'b1;
                end
            end
            r_dsh    <= DW'(kabs) << 7;
            r_step   <= 3'd7;
            r_i      <= i_win.row_lo;
            r_row_hi <= i_win.row_hi;
            r_j      <= i_win.col_lo;
            r_col_lo <= i_win.col_lo;
            r_col_hi <= i_win.col_hi;
        end else if (r_state == B_DIV) begin
            // One restoring quotient bit per cycle for all four channels.
            for (int b = 0; b < 4; b++) begin
                if (r_div_en[b] && (DW'(r_rem[b]) >= r_dsh)) begin
                    r_rem[b]         <= r_rem[b] - r_dsh[ACC_W-1:0];
                    r_q[b][r_step]   <= 1'b1;
                end
            end
            r_dsh  <= r_dsh >> 1;
            r_step <= r_step - 3'd1;
        end else if (emit) begin
            if (r_j == r_col_hi) begin
                r_j <= r_col_lo;
                r_i <= r_i + 12'd1;
            end else begin
                r_j <= r_j + COLQ_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.out_row     <= r_i;
            r_out.out_col     <= r_j[9:0];
            r_out.out_red     <= r_q[0];
            r_out.out_green   <= r_q[1];
            r_out.out_blue    <= r_q[2];
            r_out.out_alpha   <= r_q[3];
            r_out.last_of_run <= span_end;
        end
    end

    assign o_empty = !r_out_vld;
    assign o_res   = r_out;

endmodule
`default_nettype wire

// ===== hw/rtl/conv3x3_rgba_normalized.sv =====
// Top level of the streaming 3x3 RGBA convolution with kernel-sum normalization.
//
//   port group        direction  handshake           payload
//   pixel in          in         i_push / o_full     i_pix (t_pix_in)
//   filtered out      out        o_empty / i_pop     o_res (t_pix_out)
//   register write    in         i_cfg_we            i_cfg_idx, i_cfg_data
//
// A pixel that completes no window is taken without raising o_full. A pixel that
// completes a window holds the input through nine line-store reads via the
// single read port, one multiply-accumulate per tap, and a hand-off to the
// queue, which waits while the queue is full.
// A two-entry queue sits between the ends. The back end loads a window, divides for
// quotient bits 7 to 0, then emits one output per cycle unless stalled, 1 to 16 per window.
// Reset is synchronous; the line store has no reset and needs no clearing pass.
// A stalled output holds its result; the front keeps working until the queue fills.
`default_nettype none
module conv3x3_rgba_normalized import c3n_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire t_pix_in     i_pix,
    output logic             o_full,
    output logic             o_empty,
    output t_pix_out         o_res,
    input  wire logic        i_pop,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [23:0] i_cfg_data
);

    t_cfg r_cfg;
    logic win_push, win_full, win_pop, win_empty;
    t_win win_in, win_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width    <= IMAGE_WIDTH_RST;
            r_cfg.image_height   <= IMAGE_HEIGHT_RST;
            r_cfg.kernel_rows[0] <= KERNEL_TOP_RST;
            r_cfg.kernel_rows[1] <= KERNEL_MID_RST;
            r_cfg.kernel_rows[2] <= KERNEL_BOT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_IMAGE_WIDTH:   r_cfg.image_width    <= i_cfg_data[10:0];
                REG_IMAGE_HEIGHT:  r_cfg.image_height   <= i_cfg_data[11:0];
                REG_KERNEL_TOP:    r_cfg.kernel_rows[0] <= i_cfg_data;
                REG_KERNEL_MIDDLE: r_cfg.kernel_rows[1] <= i_cfg_data;
                REG_KERNEL_BOTTOM: r_cfg.kernel_rows[2] <= i_cfg_data;
                default:           r_cfg <= r_cfg;
            endcase
        end
    end

    c3n_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_push     (i_push),
        .i_pix      (i_pix),
        .o_full     (o_full),
        .o_win_push (win_push),
        .o_win      (win_in),
        .i_win_full (win_full)
    );

    c3n_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (win_push),
        .i_data  (win_in),
        .o_full  (win_full),
        .i_pop   (win_pop),
        .o_data  (win_out),
        .o_empty (win_empty)
    );

    c3n_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_win_empty (win_empty),
        .i_win       (win_out),
        .o_win_pop   (win_pop),
        .o_empty     (o_empty),
        .o_res       (o_res),
        .i_pop       (i_pop)
    );

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        win_push |-> !win_full)
        else $error("window request pushed into a full queue");

    a_pop_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        win_pop |-> !win_empty)
        else $error("window request popped from an empty queue");

    a_front_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        win_push |=> !o_full)
        else $error("front end still busy after handing off a window");

endmodule
`default_nettype wire
